@@ hw/rtl/irpw_pkg.sv @@
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants of the IR pulse-width frame transmitter.
// ----------------------------------------------------------------------------
package irpw_pkg;

  localparam int unsigned DATA_BITS  = 16;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned PAYLOAD_W  = 16;
  localparam int unsigned BIT_IDX_W  = 5;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [BIT_IDX_W-1:0] LAST_DATA_IDX = BIT_IDX_W'(DATA_BITS);
  localparam logic [BIT_IDX_W-1:0] END_IDX       = BIT_IDX_W'(DATA_BITS + 1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd4;

  localparam logic [TICK_W-1:0] HEADER_RST = 16'd600;
  localparam logic [TICK_W-1:0] SPACE_RST  = 16'd150;
  localparam logic [TICK_W-1:0] ONE_RST    = 16'd300;
  localparam logic [TICK_W-1:0] ZERO_RST   = 16'd150;
  localparam logic [TICK_W-1:0] END_RST    = 16'd300;

  typedef struct packed {
    logic                 opcode;
    logic [PAYLOAD_W-1:0] payload;
  } irpw_req_t;

  typedef struct packed {
    logic carrier_enable;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } irpw_res_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;
  } irpw_cfg_t;

endpackage

@@ hw/rtl/irpw_engine.sv @@
// ----------------------------------------------------------------------------
// irpw_engine
// Timing registers and frame state; computes one result per request.
// ----------------------------------------------------------------------------
module irpw_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  irpw_pkg::irpw_cfg_t cfg,
  input  logic                step,
  input  irpw_pkg::irpw_req_t req,
  output irpw_pkg::irpw_res_t res
);
  import irpw_pkg::*;

  logic [TICK_W-1:0]    header_r, space_r, one_r, zero_r, end_r;
  logic                 active_r, active_nxt;
  logic                 mark_r, mark_nxt;
  logic [BIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [PAYLOAD_W-1:0] bits_r, bits_nxt;
  logic [TICK_W-1:0]    elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0]    limit_r, limit_nxt;
  logic                 accepted, done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      space_r  <= SPACE_RST;
      one_r    <= ONE_RST;
      zero_r   <= ZERO_RST;
      end_r    <= END_RST;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_HEADER: header_r <= cfg.data;
        REG_SPACE:  space_r  <= cfg.data;
        REG_ONE:    one_r    <= cfg.data;
        REG_ZERO:   zero_r   <= cfg.data;
        REG_END:    end_r    <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    active_nxt  = active_r;
    mark_nxt    = mark_r;
    idx_nxt     = idx_r;
    bits_nxt    = bits_r;
    elapsed_nxt = elapsed_r;
    limit_nxt   = limit_r;
    accepted    = 1'b0;
    done        = 1'b0;
    if (step) begin
      if (req.opcode == OP_SEND) begin
        if (!active_r) begin
          active_nxt  = 1'b1;
          bits_nxt    = req.payload;
          idx_nxt     = '0;
          limit_nxt   = header_r;
          elapsed_nxt = '0;
          mark_nxt    = 1'b1;
          accepted    = 1'b1;
        end
      end else if (active_r) begin
        if (elapsed_r >= limit_r) begin
          elapsed_nxt = '0;
          if (idx_r >= END_IDX) begin
            active_nxt = 1'b0;
            mark_nxt   = 1'b0;
            idx_nxt    = '0;
            bits_nxt   = '0;
            limit_nxt  = '0;
            done       = 1'b1;
          end else if (mark_r) begin
            mark_nxt  = 1'b0;
            limit_nxt = space_r;
          end else begin
            if (idx_r == LAST_DATA_IDX) begin
              limit_nxt = end_r;
            end else if (bits_r[idx_r[SEL_W-1:0]]) begin
              limit_nxt = one_r;
            end else begin
              limit_nxt = zero_r;
            end
            mark_nxt = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
        end else begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      mark_r    <= 1'b0;
      idx_r     <= '0;
      bits_r    <= '0;
      elapsed_r <= '0;
      limit_r   <= '0;
    end else begin
      active_r  <= active_nxt;
      mark_r    <= mark_nxt;
      idx_r     <= idx_nxt;
      bits_r    <= bits_nxt;
      elapsed_r <= elapsed_nxt;
      limit_r   <= limit_nxt;
    end
  end

  assign res.carrier_enable = mark_nxt;
  assign res.busy_res       = active_nxt;
  assign res.accepted       = accepted;
  assign res.frame_done     = done;

endmodule

@@ hw/rtl/ir_pulse_width_transmitter.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_width_transmitter
// Path: an accepted request is held in the input register, and its result is registered in the result register.
// Throughput: one request per cycle while out_ready does not stall the result channel.
// Input register and result register decouple the two channels.
// Reset: synchronous active-low; idle, carrier off, timing registers at defaults.
// ----------------------------------------------------------------------------
module ir_pulse_width_transmitter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  irpw_pkg::irpw_req_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output irpw_pkg::irpw_res_t           out_data,
  input  logic                          cfg_we,
  input  logic [irpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpw_pkg::TICK_W-1:0]    cfg_data
);
  import irpw_pkg::*;

  logic      req_valid_r;
  irpw_req_t req_r;
  logic      res_valid_r;
  irpw_res_t res_r;
  logic      advance;
  irpw_res_t res_nxt;
  irpw_cfg_t cfg;

  assign advance  = !res_valid_r || out_ready;
  assign in_ready = !req_valid_r || advance;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  irpw_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (req_valid_r && advance),
    .req   (req_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> !out_data.busy_res && !out_data.carrier_enable)
    else $error("frame end left the transmitter busy");

  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> !out_data.carrier_enable)
    else $error("carrier on while idle");

  a_accept_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.busy_res && out_data.carrier_enable
      && !out_data.frame_done)
    else $error("accepted request did not start header mark");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

@@ tb/ir_pulse_width_transmitter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_width_transmitter_tb
// Self-checking bench for the IR pulse-width frame transmitter. A scripted
// opening covers reset defaults, ignored sends, all-zero phase lengths,
// stray register writes and a timing change in the middle of a phase.
// Randomized frames follow with fresh timing per burst. Each status word is
// checked against a cycle-free model of the phase timer and bit sequencer,
// with random gaps on the request side and random stalls on the status side.
// ----------------------------------------------------------------------------
module ir_pulse_width_transmitter_tb;
  import irpw_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 280;
  localparam int CALM_AFTER   = 200;

  typedef enum logic [1:0] {ROW_REQ, ROW_WRITE, ROW_FLUSH} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    irpw_req_t            req;
    logic [TICK_W-1:0]    reps;
    logic                 typed;
    irpw_res_t            want;
  } stim_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  irpw_req_t            in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  irpw_res_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data  = '0;

  logic [TICK_W-1:0]    phase_len [5];
  logic                 tx_active;
  logic                 tx_mark;
  logic [BIT_IDX_W-1:0] tx_bit;
  logic [PAYLOAD_W-1:0] tx_bits;
  logic [TICK_W-1:0]    tx_elapsed;
  logic [TICK_W-1:0]    tx_limit;

  irpw_res_t status_q [$];
  stim_row_t script [$];
  int        errors      = 0;
  int        idle_cycles = 0;
  int        stall_left  = 0;
  bit        calm        = 1'b0;
  string     field_name [4] = '{"frame_done", "accepted", "busy_res", "carrier_enable"};

  ir_pulse_width_transmitter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic irpw_res_t step_transmitter(input irpw_req_t req);
    irpw_res_t res;
    res = '0;
    if (req.opcode == OP_SEND) begin
      if (!tx_active) begin
        tx_active    = 1'b1;
        tx_bits      = req.payload;
        tx_bit       = '0;
        tx_limit     = phase_len[REG_HEADER];
        tx_elapsed   = '0;
        tx_mark      = 1'b1;
        res.accepted = 1'b1;
      end
    end else if (tx_active) begin
      if (tx_elapsed >= tx_limit) begin
        tx_elapsed = '0;
        if (tx_bit >= END_IDX) begin
          tx_active      = 1'b0;
          tx_mark        = 1'b0;
          tx_bit         = '0;
          tx_bits        = '0;
          tx_limit       = '0;
          res.frame_done = 1'b1;
        end else if (tx_mark) begin
          tx_mark  = 1'b0;
          tx_limit = phase_len[REG_SPACE];
        end else begin
          if (tx_bit == LAST_DATA_IDX)
            tx_limit = phase_len[REG_END];
          else if (tx_bits[tx_bit[3:0]])
            tx_limit = phase_len[REG_ONE];
          else
            tx_limit = phase_len[REG_ZERO];
          tx_mark = 1'b1;
          tx_bit  = tx_bit + 1'b1;
        end
      end else begin
        tx_elapsed = tx_elapsed + 1'b1;
      end
    end
    res.carrier_enable = tx_mark;
    res.busy_res       = tx_active;
    return res;
  endfunction

  function automatic stim_row_t req_row(input logic op, input logic [PAYLOAD_W-1:0] payload,
                                        input int reps, input bit typed, input logic [3:0] want);
    stim_row_t row;
    row             = '0;
    row.kind        = ROW_REQ;
    row.req.opcode  = op;
    row.req.payload = payload;
    row.reps        = TICK_W'(reps);
    row.typed       = typed;
    row.want        = irpw_res_t'(want);
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [TICK_W-1:0] val);
    stim_row_t row;
    row             = '0;
    row.kind        = ROW_WRITE;
    row.idx         = idx;
    row.req.payload = val;
    return row;
  endfunction

  function automatic stim_row_t flush_row();
    stim_row_t row;
    row      = '0;
    row.kind = ROW_FLUSH;
    return row;
  endfunction

  task automatic push_request(input irpw_req_t req, input bit typed, input irpw_res_t want);
    irpw_res_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = step_transmitter(req);
    status_q.push_back(typed ? want : predicted);
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx <= REG_END) phase_len[idx] = val;
  endtask

  always @(posedge clk) begin : status_check
    irpw_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected status, expected none, actual %b", $time, out_data);
        end else begin
          want = status_q.pop_front();
          for (int i = 0; i < 4; i++)
            if (out_data[i] !== want[i]) begin
              errors++;
              $display("%0t: %s expected %b actual %b", $time, field_name[i], want[i],
                       out_data[i]);
            end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : run
    irpw_req_t req;
    bit        was_busy;
    int        counted;
    int        burst;

    phase_len[REG_HEADER] = HEADER_RST;
    phase_len[REG_SPACE]  = SPACE_RST;
    phase_len[REG_ONE]    = ONE_RST;
    phase_len[REG_ZERO]   = ZERO_RST;
    phase_len[REG_END]    = END_RST;
    tx_active  = 1'b0;
    tx_mark    = 1'b0;
    tx_bit     = '0;
    tx_bits    = '0;
    tx_elapsed = '0;
    tx_limit   = '0;

    // defaults out of reset
    script.push_back(req_row(OP_TICK, 16'h1234, 1, 1'b1, 4'b0000));
    script.push_back(req_row(OP_SEND, 16'hA5C3, 1, 1'b1, 4'b1110));
    script.push_back(req_row(OP_SEND, 16'h0000, 1, 1'b1, 4'b1100));
    script.push_back(req_row(OP_TICK, 16'h0000, 600, 1'b0, 4'b0000));
    script.push_back(req_row(OP_TICK, 16'h0000, 1, 1'b1, 4'b0100));
    // single-tick phases; stray indexes must not alias
    script.push_back(write_row(REG_HEADER, 16'h0000));
    script.push_back(write_row(REG_SPACE, 16'h0000));
    script.push_back(write_row(REG_ONE, 16'h0000));
    script.push_back(write_row(REG_ZERO, 16'h0000));
    script.push_back(write_row(REG_END, 16'h0000));
    script.push_back(write_row(REG_END + 3'd1, 16'hFFFF));
    script.push_back(write_row(REG_END + 3'd3, 16'hFFFF));
    script.push_back(flush_row());
    script.push_back(req_row(OP_TICK, 16'hFFFF, 1, 1'b1, 4'b0000));
    script.push_back(req_row(OP_SEND, 16'hFFFF, 1, 1'b1, 4'b1110));
    script.push_back(req_row(OP_TICK, 16'h0000, 33, 1'b0, 4'b0000));
    script.push_back(req_row(OP_TICK, 16'h0000, 1, 1'b1, 4'b1100));
    script.push_back(req_row(OP_TICK, 16'h0000, 1, 1'b1, 4'b0001));
    // retime in the middle of the header
    script.push_back(write_row(REG_HEADER, 16'd3));
    script.push_back(req_row(OP_SEND, 16'h8001, 1, 1'b1, 4'b1110));
    script.push_back(req_row(OP_TICK, 16'h0000, 2, 1'b0, 4'b0000));
    script.push_back(write_row(REG_HEADER, 16'd0));
    script.push_back(write_row(REG_SPACE, 16'd2));
    script.push_back(req_row(OP_TICK, 16'h0000, 2, 1'b0, 4'b0000));
    script.push_back(flush_row());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < script.size(); r++) begin
      case (script[r].kind)
        ROW_WRITE: begin
          if (r == 0 || script[r-1].kind != ROW_WRITE) settle_pipeline();
          program_reg(script[r].idx, script[r].req.payload);
          if (r + 1 == script.size() || script[r+1].kind != ROW_WRITE) cfg_we <= 1'b0;
        end
        ROW_FLUSH: begin
          while (tx_active) begin
            req.opcode  = OP_TICK;
            req.payload = PAYLOAD_W'($urandom);
            push_request(req, 1'b0, '0);
          end
        end
        default: begin
          repeat (script[r].reps) push_request(script[r].req, script[r].typed, script[r].want);
        end
      endcase
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      settle_pipeline();
      for (int i = REG_HEADER; i <= REG_END; i++)
        program_reg(CFG_IDX_W'(i), ($urandom_range(0, 5) == 0) ? TICK_W'($urandom_range(0, 40))
                                                               : TICK_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0)
        program_reg(CFG_IDX_W'($urandom_range(REG_END + 1, (1 << CFG_IDX_W) - 1)),
                    TICK_W'($urandom));
      cfg_we <= 1'b0;
      burst = $urandom_range(20, 150);
      repeat (burst) begin
        was_busy    = tx_active;
        req.payload = PAYLOAD_W'($urandom);
        if (was_busy)
          req.opcode = ($urandom_range(0, 19) == 0) ? OP_SEND : OP_TICK;
        else
          req.opcode = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_SEND;
        push_request(req, 1'b0, '0);
        if (was_busy ? (req.opcode == OP_TICK) : (req.opcode == OP_SEND)) counted++;
      end
      calm = (counted >= CALM_AFTER);
    end

    settle_pipeline();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
